>>> hw/rtl/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Types, constants and operation codes shared by the fixed-point ALU.
// ----------------------------------------------------------------------------
package qfa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int OP_W      = 3;

  // divider: 16 quotient bits, resolved four per pipeline stage
  localparam int DIV_Q_W    = 16;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;
  localparam int NMAG_W     = DATA_W + FRAC_BITS;
  localparam int CMP_W      = DATA_W + DIV_Q_W;
  localparam int PROD_W     = 2 * DATA_W;

  localparam logic signed [DATA_W-1:0] Q16_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] Q16_MAX = 16'sh7fff;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_FLOOR = 3'd4,
    OP_CEIL  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  simple_res;
    logic                      lt;
    logic                      eq;
    logic                      gt;
    logic signed [PROD_W-1:0]  prod;
    logic [DATA_W-1:0]         dmag;
    logic [DATA_W-1:0]         rem;
    logic [DIV_Q_W-1:0]        nlow;
    logic [DIV_Q_W-1:0]        quo;
    logic                      neg;
    logic                      dovf;
    logic                      dz;
    logic                      a_sign;
    logic                      a_zero;
  } pipe_t;

endpackage

>>> hw/rtl/qfa_in_if.sv
// ----------------------------------------------------------------------------
// qfa_in_if
// Input channel of the fixed-point ALU: operation and two raw operands.
// ----------------------------------------------------------------------------
interface qfa_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic signed [15:0]  operand_a;
  logic signed [15:0]  operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

>>> hw/rtl/qfa_out_if.sv
// ----------------------------------------------------------------------------
// qfa_out_if
// Result channel of the fixed-point ALU: result value and status flags.
// ----------------------------------------------------------------------------
interface qfa_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  result;
  logic                is_less;
  logic                is_equal;
  logic                is_greater;
  logic                overflow;
  logic                div_zero;

  modport source (output valid, output result, output is_less, output is_equal,
                  output is_greater, output overflow, output div_zero, input ready);
  modport sink   (input valid, input result, input is_less, input is_equal,
                  input is_greater, input overflow, input div_zero, output ready);
endinterface

>>> hw/rtl/q_format_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// q_format_fixed_point_alu_unit
// Signed 16-bit Q-format ALU: add, subtract, multiply, divide, floor, ceil.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the first stage can take it, and presents
// each result on the output in input order, through six register
// stages: one setup stage (compares, add/sub, floor/ceil, 16x16 product), four
// divider stages of four quotient bits each, and one output stage that scales
// the product and signs and saturates the quotient. Each stage holds its item
// while the next one is full, so the block keeps taking items into empty
// stages while a result waits at the output.
module q_format_fixed_point_alu_unit (
  input  logic      clk,
  input  logic      rst_n,
  qfa_in_if.sink    in_ch,
  qfa_out_if.source out_ch
);
  import qfa_pkg::*;

  logic  stg_valid [DIV_STAGES+1];
  logic  stg_ready [DIV_STAGES+1];
  pipe_t stg_data  [DIV_STAGES+1];

  qfa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    qfa_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  qfa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[DIV_STAGES]),
    .up_ready (stg_ready[DIV_STAGES]),
    .up_data  (stg_data[DIV_STAGES]),
    .out_ch   (out_ch)
  );

endmodule

>>> hw/rtl/qfa_front.sv
// ----------------------------------------------------------------------------
// qfa_front
// First stage: compare flags, simple ops, product, divider operand setup.
// ----------------------------------------------------------------------------
module qfa_front (
  input  logic          clk,
  input  logic          rst_n,
  qfa_in_if.sink        in_ch,
  output logic          dn_valid,
  input  logic          dn_ready,
  output qfa_pkg::pipe_t dn_data
);
  import qfa_pkg::*;

  localparam logic signed [DATA_W:0] RND = (DATA_W+1)'((1 << FRAC_BITS) - 1);

  logic               v_r;
  pipe_t              d_r;
  pipe_t              d_nxt;
  logic               en;

  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W-1:0] b;
  op_t                      op;
  logic signed [DATA_W:0]   ceil_sum;
  logic signed [DATA_W:0]   ceil_sh;
  logic [DATA_W-1:0]        amag;
  logic [NMAG_W-1:0]        nmag;

  assign en          = !v_r || dn_ready;
  assign in_ch.ready = en;
  assign dn_valid    = v_r;
  assign dn_data     = d_r;

  always_comb begin
    a        = in_ch.operand_a;
    b        = in_ch.operand_b;
    op       = op_t'(in_ch.operation);
    ceil_sum = {a[DATA_W-1], a} + RND;
    ceil_sh  = ceil_sum >>> FRAC_BITS;
    amag     = a[DATA_W-1] ? (~a + 1'b1) : a;
    nmag     = {amag, {FRAC_BITS{1'b0}}};

    d_nxt        = '0;
    d_nxt.op     = op;
    d_nxt.lt     = (a < b);
    d_nxt.eq     = (a == b);
    d_nxt.gt     = (a > b);
    d_nxt.prod   = PROD_W'(a) * PROD_W'(b);
    d_nxt.dmag   = b[DATA_W-1] ? (~b + 1'b1) : b;
    d_nxt.rem    = DATA_W'(nmag[NMAG_W-1:DIV_Q_W]);
    d_nxt.nlow   = nmag[DIV_Q_W-1:0];
    d_nxt.quo    = '0;
    d_nxt.neg    = a[DATA_W-1] ^ b[DATA_W-1];
    d_nxt.dovf   = CMP_W'(nmag) >= {d_nxt.dmag, {DIV_Q_W{1'b0}}};
    d_nxt.dz     = (b == '0);
    d_nxt.a_sign = a[DATA_W-1];
    d_nxt.a_zero = (a == '0);

    case (op)
      OP_ADD:   d_nxt.simple_res = a + b;
      OP_SUB:   d_nxt.simple_res = a - b;
      OP_FLOOR: d_nxt.simple_res = a >>> FRAC_BITS;
      OP_CEIL:  d_nxt.simple_res = ceil_sh[DATA_W-1:0];
      default:  d_nxt.simple_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_ch.valid;
    end
    if (en && in_ch.valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/qfa_div_stage.sv
// ----------------------------------------------------------------------------
// qfa_div_stage
// Restoring divider slice: resolves DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module qfa_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  qfa_pkg::pipe_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output qfa_pkg::pipe_t dn_data
);
  import qfa_pkg::*;

  logic              v_r;
  pipe_t             d_r;
  pipe_t             d_nxt;
  logic              en;
  logic [DATA_W:0]   trial;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    d_nxt = up_data;
    trial = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial      = {d_nxt.rem, d_nxt.nlow[DIV_Q_W-1]};
      d_nxt.nlow = {d_nxt.nlow[DIV_Q_W-2:0], 1'b0};
      if (trial >= {1'b0, d_nxt.dmag}) begin
        trial     = trial - {1'b0, d_nxt.dmag};
        d_nxt.quo = {d_nxt.quo[DIV_Q_W-2:0], 1'b1};
      end else begin
        d_nxt.quo = {d_nxt.quo[DIV_Q_W-2:0], 1'b0};
      end
      d_nxt.rem = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
    if (en && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/qfa_back.sv
// ----------------------------------------------------------------------------
// qfa_back
// Last stage: multiply scaling, quotient sign and saturation, result select.
// ----------------------------------------------------------------------------
module qfa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  qfa_pkg::pipe_t up_data,
  qfa_out_if.source      out_ch
);
  import qfa_pkg::*;

  localparam logic signed [PROD_W:0] RND = (PROD_W+1)'((1 << FRAC_BITS) - 1);
  localparam logic signed [PROD_W:0] MAX_W = (PROD_W+1)'(Q16_MAX);
  localparam logic signed [PROD_W:0] MIN_W = (PROD_W+1)'(Q16_MIN);
  localparam logic [DIV_Q_W-1:0] QMAX_POS = DIV_Q_W'(Q16_MAX);
  localparam logic [DIV_Q_W-1:0] QMAX_NEG = DIV_Q_W'(Q16_MAX) + 1'b1;

  logic                     v_r;
  logic signed [DATA_W-1:0] res_r;
  logic                     lt_r, eq_r, gt_r, ovf_r, dz_r;
  logic signed [DATA_W-1:0] res_nxt;
  logic                     ovf_nxt;
  logic                     en;

  logic signed [PROD_W:0]   padj;
  logic signed [PROD_W:0]   mq;
  logic signed [DATA_W-1:0] mul_res;
  logic                     mul_ovf;
  logic signed [DATA_W-1:0] div_res;
  logic                     div_ovf;

  assign en       = !v_r || out_ch.ready;
  assign up_ready = en;

  always_comb begin
    padj = up_data.prod[PROD_W-1] ? ({up_data.prod[PROD_W-1], up_data.prod} + RND)
                                  : {up_data.prod[PROD_W-1], up_data.prod};
    mq   = padj >>> FRAC_BITS;
    if (mq > MAX_W) begin
      mul_res = Q16_MAX;
      mul_ovf = 1'b1;
    end else if (mq < MIN_W) begin
      mul_res = Q16_MIN;
      mul_ovf = 1'b1;
    end else begin
      mul_res = mq[DATA_W-1:0];
      mul_ovf = 1'b0;
    end

    div_ovf = 1'b0;
    if (up_data.dz) begin
      div_res = up_data.a_zero ? '0 : (up_data.a_sign ? Q16_MIN : Q16_MAX);
    end else if (up_data.dovf) begin
      div_res = up_data.neg ? Q16_MIN : Q16_MAX;
      div_ovf = 1'b1;
    end else if (up_data.neg) begin
      if (up_data.quo > QMAX_NEG) begin
        div_res = Q16_MIN;
        div_ovf = 1'b1;
      end else begin
        div_res = ~up_data.quo + 1'b1;
      end
    end else if (up_data.quo > QMAX_POS) begin
      div_res = Q16_MAX;
      div_ovf = 1'b1;
    end else begin
      div_res = up_data.quo;
    end

    case (up_data.op)
      OP_MUL: begin
        res_nxt = mul_res;
        ovf_nxt = mul_ovf;
      end
      OP_DIV: begin
        res_nxt = div_res;
        ovf_nxt = div_ovf;
      end
      default: begin
        res_nxt = up_data.simple_res;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
    if (en && up_valid) begin
      res_r <= res_nxt;
      lt_r  <= up_data.lt;
      eq_r  <= up_data.eq;
      gt_r  <= up_data.gt;
      ovf_r <= ovf_nxt;
      dz_r  <= (up_data.op == OP_DIV) && up_data.dz;
    end
  end

  assign out_ch.valid      = v_r;
  assign out_ch.result     = res_r;
  assign out_ch.is_less    = lt_r;
  assign out_ch.is_equal   = eq_r;
  assign out_ch.is_greater = gt_r;
  assign out_ch.overflow   = ovf_r;
  assign out_ch.div_zero   = dz_r;

endmodule

>>> hw/rtl/qfa_checker.sv
// ----------------------------------------------------------------------------
// qfa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module qfa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_result,
  input logic               out_is_less,
  input logic               out_is_equal,
  input logic               out_is_greater,
  input logic               out_overflow,
  input logic               out_div_zero
);

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled item changed or dropped");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_is_less, out_is_equal, out_is_greater}))
    else $error("compare flags not exclusive");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      !out_div_zero && (out_result == 16'sh7fff || out_result == 16'sh8000))
    else $error("overflow without saturated result");

  // divide by zero: sign of a shows in both result and compare against zero
  a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |->
      (out_result == 16'sh7fff && out_is_greater) ||
      (out_result == 16'sh8000 && out_is_less) ||
      (out_result == 16'sh0000 && out_is_equal))
    else $error("divide by zero result mismatch");

endmodule

bind q_format_fixed_point_alu_unit qfa_checker u_qfa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_result     (out_ch.result),
  .out_is_less    (out_ch.is_less),
  .out_is_equal   (out_ch.is_equal),
  .out_is_greater (out_ch.is_greater),
  .out_overflow   (out_ch.overflow),
  .out_div_zero   (out_ch.div_zero)
);
